[rtl/csb_pkg.sv]
// Shared types and codes for the cursor sequence buffer.
package csb_pkg;

   typedef enum logic [2:0] {
      KIND_START   = 3'd0,
      KIND_ADVANCE = 3'd1,
      KIND_INSERT  = 3'd2,
      KIND_ATTACH  = 3'd3,
      KIND_REMOVE  = 3'd4,
      KIND_READ    = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_FULL       = 2'd1,
      ST_NO_CURRENT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SH_RD,
      S_SH_WR,
      S_PUT,
      S_LOOK,
      S_WAIT
   } state_type;

   localparam int KIND_WIDTH   = 3;
   localparam int STATUS_WIDTH = 2;

endpackage

[rtl/csb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module csb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/csb_ctrl.sv]
// Sequencer: decodes a transaction, shifts entries through the RAM, builds the result.
module csb_ctrl
   import csb_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [KIND_WIDTH-1:0]          req_kind,
   input  logic [VALUE_WIDTH-1:0]         req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [STATUS_WIDTH-1:0]        rsp_status,
   output logic                           rsp_has_current,
   output logic [VALUE_WIDTH-1:0]         rsp_value,
   output logic [$clog2(CAPACITY+1)-1:0]  rsp_count,
   output logic                           mem_we,
   output logic [$clog2(CAPACITY)-1:0]    mem_waddr,
   output logic [VALUE_WIDTH-1:0]         mem_wdata,
   output logic [$clog2(CAPACITY)-1:0]    mem_raddr,
   input  logic [VALUE_WIDTH-1:0]         mem_rdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE = CW'(1);

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    cursor_ff, cursor_in;
   logic [CW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    pos_ff, pos_in;
   logic             up_ff, up_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   status_type       status_ff, status_in;

   logic                    out_valid_ff, out_valid_in;
   logic [STATUS_WIDTH-1:0] out_status_ff, out_status_in;
   logic                    out_has_ff, out_has_in;
   logic [VALUE_WIDTH-1:0]  out_value_ff, out_value_in;
   logic [CW-1:0]           out_count_ff, out_count_in;

   logic          accept;
   logic          present;
   logic          full;
   logic          out_free;
   logic          shift_last;
   logic [CW-1:0] ins_pos;
   logic [CW-1:0] att_pos;

   assign present  = cursor_ff < count_ff;
   assign full     = count_ff >= CAP;
   assign out_free = !out_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;
   assign ins_pos  = present ? cursor_ff : '0;
   assign att_pos  = present ? cursor_ff + ONE : count_ff;
   assign shift_last = up_ff ? (ptr_ff == pos_ff) : (ptr_ff == count_ff - ONE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
               case (kind_type'(req_kind))
                  KIND_INSERT: begin
                     if (!full) begin
                        state_in = (ins_pos < count_ff) ? S_SH_RD : S_PUT;
                     end
                  end
                  KIND_ATTACH: begin
                     if (!full) begin
                        state_in = (att_pos < count_ff) ? S_SH_RD : S_PUT;
                     end
                  end
                  KIND_REMOVE: begin
                     if (present && (cursor_ff + ONE < count_ff)) begin
                        state_in = S_SH_RD;
                     end
                  end
                  default: state_in = S_LOOK;
               endcase
            end
         end
         S_SH_RD: state_in = S_SH_WR;
         S_SH_WR: begin
            if (!shift_last) begin
               state_in = S_SH_RD;
            end else if (up_ff) begin
               state_in = S_PUT;
            end else begin
               state_in = S_LOOK;
            end
         end
         S_PUT:  state_in = S_LOOK;
         S_LOOK: state_in = S_WAIT;
         S_WAIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs: handshake and RAM port
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = mem_rdata;
      mem_raddr = '0;
      case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_SH_RD: mem_raddr = ptr_ff[AW-1:0];
         S_SH_WR: begin
            mem_we    = 1'b1;
            mem_waddr = up_ff ? AW'(ptr_ff + ONE) : AW'(ptr_ff - ONE);
         end
         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[AW-1:0];
            mem_wdata = val_ff;
         end
         S_LOOK, S_WAIT: begin
            // cursor may equal capacity; park the address then
            mem_raddr = present ? cursor_ff[AW-1:0] : '0;
         end
         default: req_ready = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      up_in         = up_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_has_in    = out_has_ff;
      out_value_in  = out_value_ff;
      out_count_in  = out_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in    = req_value;
               status_in = ST_DONE;
               case (kind_type'(req_kind))
                  KIND_START: cursor_in = '0;
                  KIND_ADVANCE: begin
                     if (present) begin
                        cursor_in = cursor_ff + ONE;
                     end else begin
                        status_in = ST_NO_CURRENT;
                     end
                  end
                  KIND_INSERT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        pos_in = ins_pos;
                        ptr_in = count_ff - ONE;
                        up_in  = 1'b1;
                     end
                  end
                  KIND_ATTACH: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        pos_in = att_pos;
                        ptr_in = count_ff - ONE;
                        up_in  = 1'b1;
                     end
                  end
                  KIND_REMOVE: begin
                     if (!present) begin
                        status_in = ST_NO_CURRENT;
                     end else begin
                        ptr_in = cursor_ff + ONE;
                        up_in  = 1'b0;
                        // removing the last entry needs no shift
                        if (!(cursor_ff + ONE < count_ff)) begin
                           count_in = count_ff - ONE;
                        end
                     end
                  end
                  default: status_in = ST_DONE;
               endcase
            end
         end
         S_SH_WR: begin
            if (shift_last) begin
               if (!up_ff) begin
                  count_in = count_ff - ONE;
               end
            end else begin
               ptr_in = up_ff ? ptr_ff - ONE : ptr_ff + ONE;
            end
         end
         S_PUT: begin
            count_in  = count_ff + ONE;
            cursor_in = pos_ff;
         end
         S_WAIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_has_in    = present;
               out_value_in  = present ? mem_rdata : '0;
               out_count_in  = count_ff;
            end
         end
         default: ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         out_valid_ff <= out_valid_in;
      end
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      up_ff         <= up_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      out_status_ff <= out_status_in;
      out_has_ff    <= out_has_in;
      out_value_ff  <= out_value_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_has_current = out_has_ff;
   assign rsp_value       = out_value_ff;
   assign rsp_count       = out_count_ff;

endmodule

[rtl/cursor_sequence_buffer_top.sv]
// Top level of the cursor sequence buffer: sequencer plus entry RAM.
//
// Request channel (req_*): one transaction per operation; req_tuser carries
// the kind, req_tdata the value for insert and attach.
// Response channel (rsp_*): exactly one transaction per request with status,
// current flag, current value and entry count after the operation.
// Entries live in one RAM with registered read. Start, advance, read and
// rejected operations go from accept through the look and wait states to the
// response register. Insert, attach and remove first move entries, each move a
// RAM read followed by a RAM write; insert and attach then write the new entry.
// One operation is in flight at a time; req_tready is high only while the
// sequencer is idle. The response sits in an output register, so the next
// request is accepted while it still waits; a stalled receiver holds the
// finished result and, once a second result is ready, stops the sequencer.
// Synchronous reset empties the buffer and puts the cursor at the front;
// RAM contents are not cleared, since only written entries are ever read.
module cursor_sequence_buffer_top
   import csb_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0] req_tdata,   // entry_value
   input  logic [KIND_WIDTH-1:0] req_tuser,              // kind
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status, has_current, current_value, count
   output logic [((STATUS_WIDTH+1+VALUE_WIDTH+$clog2(CAPACITY+1)+7)/8)*8-1:0] rsp_tdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int OW = ((STATUS_WIDTH + 1 + VALUE_WIDTH + CW + 7) / 8) * 8;
   localparam int PAD = OW - (STATUS_WIDTH + 1 + VALUE_WIDTH + CW);

   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [VALUE_WIDTH-1:0]  mem_wdata;
   logic [AW-1:0]           mem_raddr;
   logic [VALUE_WIDTH-1:0]  mem_rdata;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic                    rsp_has_current;
   logic [VALUE_WIDTH-1:0]  rsp_value;
   logic [CW-1:0]           rsp_count;

   csb_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_kind        (req_tuser),
      .req_value       (req_tdata[VALUE_WIDTH-1:0]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_has_current (rsp_has_current),
      .rsp_value       (rsp_value),
      .rsp_count       (rsp_count),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata)
   );

   csb_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rsp_tdata = {{PAD{1'b0}}, rsp_count, rsp_value, rsp_has_current, rsp_status};

   // count never goes past capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_count <= CW'(CAPACITY)))
      else $error("count beyond capacity");

   // no current entry means a zero value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_has_current) |-> (rsp_value == '0))
      else $error("value without current entry");

   // a current entry means the count is not zero
   a_current_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_has_current) |-> (rsp_count != '0))
      else $error("current entry in empty buffer");

   // one operation in flight: no accept right after an accept
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while busy");

   // RAM writes stay inside the array
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ({1'b0, mem_waddr} < (AW+1)'(CAPACITY)))
      else $error("RAM write out of range");

endmodule

[dv/cursor_sequence_buffer_top_tb.sv]
// Self-checking testbench for the cursor sequence buffer top level.
`timescale 1ns / 1ps

module cursor_sequence_buffer_top_tb;
   import csb_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int REQ_WIDTH   = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_WIDTH   = ((STATUS_WIDTH + 1 + VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

   // response field offsets, lowest field first
   localparam int HAS_CUR_BIT = STATUS_WIDTH;
   localparam int VALUE_LSB   = STATUS_WIDTH + 1;
   localparam int COUNT_LSB   = VALUE_LSB + VALUE_WIDTH;
   localparam int PAD_LSB     = COUNT_LSB + COUNT_WIDTH;

   // kinds with no operation of their own; the block treats them as a read
   localparam logic [KIND_WIDTH-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_WIDTH-1:0] KIND_SPARE_B = 3'd7;

   localparam int RANDOM_ITEMS = 650;
   localparam int MAX_GAP      = 12;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 300;

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_WALK, MIX_ANY} traffic_mix_type;

   typedef struct {
      status_type             status;
      logic                   has_current;
      logic [VALUE_WIDTH-1:0] value;
      logic [COUNT_WIDTH-1:0] count;
   } buffer_result_type;

   class buffer_tracker;
      logic [VALUE_WIDTH-1:0] entries [CAPACITY];
      int unsigned            count_now;
      int unsigned            cursor_now;
      buffer_result_type      pending_results [$];
      int                     errors;

      function new();
         count_now  = 0;
         cursor_now = 0;
         errors     = 0;
      endfunction

      task report(input string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      // apply one accepted operation to the buffer image and queue its result
      function void note_request(input logic [KIND_WIDTH-1:0] kind,
                                 input logic [VALUE_WIDTH-1:0] value);
         bit                present;
         int unsigned       pos;
         int unsigned       i;
         buffer_result_type res;
         present    = cursor_now < count_now;
         res.status = ST_DONE;
         case (kind)
            KIND_START: begin
               cursor_now = 0;
            end
            KIND_ADVANCE: begin
               if (present) cursor_now++;
               else res.status = ST_NO_CURRENT;
            end
            KIND_INSERT, KIND_ATTACH: begin
               if (count_now >= CAPACITY) begin
                  res.status = ST_FULL;
               end else begin
                  if (kind == KIND_INSERT) pos = present ? cursor_now : 0;
                  else pos = present ? cursor_now + 1 : count_now;
                  for (i = count_now; i > pos; i--) entries[i] = entries[i-1];
                  entries[pos] = value;
                  count_now++;
                  cursor_now = pos;
               end
            end
            KIND_REMOVE: begin
               if (!present) begin
                  res.status = ST_NO_CURRENT;
               end else begin
                  for (i = cursor_now; i + 1 < count_now; i++) entries[i] = entries[i+1];
                  count_now--;
               end
            end
            default: ;
         endcase
         present         = cursor_now < count_now;
         res.has_current = present;
         res.value       = present ? entries[cursor_now] : '0;
         res.count       = count_now[COUNT_WIDTH-1:0];
         pending_results.push_back(res);
      endfunction

      task check_response(input logic [RSP_WIDTH-1:0] word);
         buffer_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("response %h with none outstanding", word));
            return;
         end
         want = pending_results.pop_front();
         if (word[STATUS_WIDTH-1:0] !== want.status)
            report($sformatf("status %0d, want %0d", word[STATUS_WIDTH-1:0], want.status));
         if (word[HAS_CUR_BIT] !== want.has_current)
            report($sformatf("has_current %b, want %b", word[HAS_CUR_BIT], want.has_current));
         if (word[COUNT_LSB-1:VALUE_LSB] !== want.value)
            report($sformatf("current_value %h, want %h",
                             word[COUNT_LSB-1:VALUE_LSB], want.value));
         if (word[PAD_LSB-1:COUNT_LSB] !== want.count)
            report($sformatf("count %0d, want %0d", word[PAD_LSB-1:COUNT_LSB], want.count));
         if (word[RSP_WIDTH-1:PAD_LSB] !== '0)
            report($sformatf("padding bits %h not zero", word[RSP_WIDTH-1:PAD_LSB]));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_WIDTH-1:0]   req_tdata;   // entry_value
   logic [KIND_WIDTH-1:0]  req_tuser;   // kind
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // status, has_current, current_value, count
   logic [RSP_WIDTH-1:0]   rsp_tdata;

   buffer_tracker tracker;
   bit            sender_no_gaps;
   bit            receiver_no_stalls;
   bit            hold_pending;

   cursor_sequence_buffer_top #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // called at a falling edge; returns at the falling edge after the accept
   task automatic send_request(input logic [KIND_WIDTH-1:0] kind,
                               input logic [VALUE_WIDTH-1:0] value);
      int gap;
      gap = sender_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = '0;
      req_tdata[VALUE_WIDTH-1:0] = value;
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.note_request(kind, value);
      @(negedge clock);
   endtask

   function automatic logic [KIND_WIDTH-1:0] pick_kind(input traffic_mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_GROW: begin
            if (r < 45) return KIND_INSERT;
            if (r < 85) return KIND_ATTACH;
            if (r < 91) return KIND_ADVANCE;
            if (r < 96) return KIND_START;
            return KIND_REMOVE;
         end
         MIX_SHRINK: begin
            if (r < 55) return KIND_REMOVE;
            if (r < 70) return KIND_ADVANCE;
            if (r < 85) return KIND_START;
            if (r < 90) return KIND_INSERT;
            if (r < 95) return KIND_ATTACH;
            return KIND_READ;
         end
         MIX_WALK: begin
            if (r < 20) return KIND_START;
            if (r < 60) return KIND_ADVANCE;
            if (r < 68) return KIND_READ;
            if (r < 72) return KIND_SPARE_A;
            if (r < 75) return KIND_SPARE_B;
            if (r < 85) return KIND_REMOVE;
            if (r < 93) return KIND_INSERT;
            return KIND_ATTACH;
         end
         default: return KIND_WIDTH'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return VALUE_WIDTH'($urandom);
   endfunction

   // sink side: random ready stalls, plus one long hold-off on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready   = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = receiver_no_stalls ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         tracker.check_response(rsp_tdata);
      end
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      traffic_mix_type mix;
      int              items_sent;
      int              episode;
      int              length;
      tracker            = new();
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      req_tuser          = KIND_READ;
      sender_no_gaps     = 1'b0;
      receiver_no_stalls = 1'b0;
      hold_pending       = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty buffer corners
      send_request(KIND_READ, pick_value());
      send_request(KIND_ADVANCE, pick_value());
      send_request(KIND_REMOVE, pick_value());
      send_request(KIND_START, pick_value());
      // insert with no current lands at the front, attach goes after cursor
      send_request(KIND_INSERT, '1);
      send_request(KIND_ATTACH, '0);
      send_request(KIND_ADVANCE, pick_value());   // walks off the end
      send_request(KIND_ADVANCE, pick_value());   // nothing current
      send_request(KIND_ATTACH, 32'h1234_5678);   // no current: to the end
      send_request(KIND_ADVANCE, pick_value());
      send_request(KIND_INSERT, 32'hA5A5_A5A5);   // no current: to the front
      send_request(KIND_INSERT, 32'h5A5A_5A5A);   // before the cursor
      send_request(KIND_ADVANCE, pick_value());
      send_request(KIND_ATTACH, 32'h8000_0001);   // middle
      send_request(KIND_REMOVE, pick_value());    // next entry becomes current
      send_request(KIND_SPARE_A, pick_value());
      send_request(KIND_SPARE_B, pick_value());
      send_request(KIND_START, pick_value());
      send_request(KIND_REMOVE, pick_value());    // front
      send_request(KIND_ADVANCE, pick_value());
      send_request(KIND_ADVANCE, pick_value());
      send_request(KIND_ADVANCE, pick_value());
      send_request(KIND_REMOVE, pick_value());    // last one: no current after
      send_request(KIND_REMOVE, pick_value());
      send_request(KIND_READ, pick_value());

      items_sent = 0;
      episode    = 0;
      while (items_sent < RANDOM_ITEMS) begin
         mix = (episode == 0) ? MIX_GROW : traffic_mix_type'($urandom_range(0, 3));
         length = (mix == MIX_GROW) ? $urandom_range(70, 110) : $urandom_range(15, 60);
         if (length > RANDOM_ITEMS - items_sent) length = RANDOM_ITEMS - items_sent;
         sender_no_gaps     = ($urandom_range(0, 3) == 0);
         receiver_no_stalls = ($urandom_range(0, 3) == 0);
         if (episode == 2) begin
            // back up the result path while requests keep coming
            hold_pending   = 1'b1;
            sender_no_gaps = 1'b1;
         end
         repeat (length) begin
            send_request(pick_kind(mix), pick_value());
            items_sent++;
         end
         episode++;
      end
      req_tvalid = 1'b0;

      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
